// File: src/tcrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tcrq_pkg;

    localparam int CHANNELS    = 8;
    localparam int MAX_HISTORY = 16;
    localparam int CH_IDX_W    = $clog2(CHANNELS);

    localparam int DATA_W      = 16;
    localparam int WEIGHT_W    = 9;
    localparam int HLEN_W      = 5;

    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int MAC_STEPS   = WEIGHT_W;
    localparam int MAC_CNT_W   = $clog2(MAC_STEPS);
    localparam int ACC_W       = DATA_W + WEIGHT_W;

    localparam logic [DATA_W-1:0]   MIN_VALID_MM = 16'd30;
    localparam logic [DATA_W-1:0]   FAR_MM       = 16'd4000;
    localparam logic [WEIGHT_W-1:0] FULL_WEIGHT  = 9'd256;

    localparam logic [DATA_W-1:0]   RST_AMB_THR  = 16'd100;
    localparam logic [HLEN_W-1:0]   RST_HIST_LEN = 5'd4;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT   = 9'd256;

    typedef enum logic [1:0] {
        REG_AMB_THR  = 2'd0,
        REG_HIST_LEN = 2'd1,
        REG_WEIGHT   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic start;
    } t_unit_ctl;

    // window of the newest len flags; zero counts as one, long ones clamp
    function automatic logic [MAX_HISTORY-1:0] hist_mask(input logic [HLEN_W-1:0] len);
        logic [MAX_HISTORY-1:0] m;
        int eff;
        eff = int'(len);
        if (eff == 0) eff = 1;
        if (eff > MAX_HISTORY) eff = MAX_HISTORY;
        for (int i = 0; i < MAX_HISTORY; i++) begin
            m[i] = (i < eff);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// File: src/tcrq_div.sv
`timescale 1ns / 1ps
`default_nettype none
module tcrq_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tcrq_pkg::t_unit_ctl          i_ctl,
    input  wire logic [tcrq_pkg::DATA_W-1:0]  i_dividend,
    input  wire logic [tcrq_pkg::DATA_W-1:0]  i_divisor,
    output logic                              o_done,
    output logic [tcrq_pkg::DATA_W-1:0]       o_quotient
);

    logic                             r_busy, n_busy;
    logic                             r_done, n_done;
    logic [tcrq_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [tcrq_pkg::DATA_W-1:0]      r_rem, n_rem;
    logic [tcrq_pkg::DATA_W-1:0]      r_quo, n_quo;
    logic [tcrq_pkg::DATA_W-1:0]      r_den, n_den;
    logic [tcrq_pkg::DATA_W+1:0]      w_diff;

    // restoring division, one quotient bit per cycle; a zero divisor never
    // borrows, so the quotient comes out all ones
    assign w_diff = {1'b0, r_rem, r_quo[tcrq_pkg::DATA_W-1]} - {2'b00, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_den  = i_divisor;
        end else if (r_busy) begin
            if (!w_diff[tcrq_pkg::DATA_W+1]) begin
                n_rem = w_diff[tcrq_pkg::DATA_W-1:0];
            end else begin
                n_rem = {r_rem[tcrq_pkg::DATA_W-2:0], r_quo[tcrq_pkg::DATA_W-1]};
            end
            n_quo = {r_quo[tcrq_pkg::DATA_W-2:0], ~w_diff[tcrq_pkg::DATA_W+1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == tcrq_pkg::DIV_CNT_W'(tcrq_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// File: src/tcrq_mac.sv
`timescale 1ns / 1ps
`default_nettype none
module tcrq_mac (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire tcrq_pkg::t_unit_ctl            i_ctl,
    input  wire logic [tcrq_pkg::DATA_W-1:0]    i_cur,
    input  wire logic [tcrq_pkg::DATA_W-1:0]    i_stored,
    input  wire logic [tcrq_pkg::WEIGHT_W-1:0]  i_weight,
    output logic                                o_done,
    output logic [tcrq_pkg::DATA_W-1:0]         o_result
);

    logic                             r_busy, n_busy;
    logic                             r_done, n_done;
    logic [tcrq_pkg::MAC_CNT_W-1:0]   r_cnt, n_cnt;
    logic [tcrq_pkg::WEIGHT_W-1:0]    r_w, n_w;
    logic [tcrq_pkg::WEIGHT_W-1:0]    r_wb, n_wb;
    logic [tcrq_pkg::DATA_W-1:0]      r_cur, n_cur;
    logic [tcrq_pkg::DATA_W-1:0]      r_sto, n_sto;
    logic [tcrq_pkg::ACC_W-1:0]       r_acc, n_acc;

    // stored*(256-w) + cur*w, both weights walked MSB first, one bit a cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_w    = r_w;
        n_wb   = r_wb;
        n_cur  = r_cur;
        n_sto  = r_sto;
        n_acc  = r_acc;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_w    = i_weight;
            n_wb   = tcrq_pkg::FULL_WEIGHT - i_weight;
            n_cur  = i_cur;
            n_sto  = i_stored;
            n_acc  = '0;
        end else if (r_busy) begin
            n_acc = {r_acc[tcrq_pkg::ACC_W-2:0], 1'b0}
                  + (r_w[tcrq_pkg::WEIGHT_W-1]  ? tcrq_pkg::ACC_W'(r_cur) : '0)
                  + (r_wb[tcrq_pkg::WEIGHT_W-1] ? tcrq_pkg::ACC_W'(r_sto) : '0);
            n_w   = {r_w[tcrq_pkg::WEIGHT_W-2:0], 1'b0};
            n_wb  = {r_wb[tcrq_pkg::WEIGHT_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == tcrq_pkg::MAC_CNT_W'(tcrq_pkg::MAC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_w   <= n_w;
        r_wb  <= n_wb;
        r_cur <= n_cur;
        r_sto <= n_sto;
        r_acc <= n_acc;
    end

    assign o_done   = r_done;
    assign o_result = r_acc[tcrq_pkg::DATA_W+7:8];

endmodule
`default_nettype wire

// File: src/tof_channel_range_qualifier.sv
// Ranging result qualifier for a bank of time-of-flight sensor channels.
// Input channel: i_in_valid / o_in_stall with channel, distance, range status,
// raw ambient and SPAD count; a word is taken when valid is high and stall low.
// Output channel: o_out_valid / i_out_stall with channel, filtered distance,
// ambient per SPAD and the current and recent robot flags, one word per input.
// Config: i_cfg_we writes i_cfg_data into the register picked by i_cfg_index
// (0 ambient threshold, 1 history length, 2 smoothing weight); write only
// while the block is idle.
// One word is processed at a time: a bit-serial divider produces ambient per
// SPAD, then a bit-serial multiply-accumulate applies the smoothing weight.
// A new word is taken only once the previous result has moved to the output
// register, so the input stalls while those two serial units run.
// A finished word sits in the output register while the next one is worked
// on; if the receiver still stalls when the next result is ready, the block
// holds that result and stalls its input until the output register frees up.
// Reset clears the per-channel distances and flag histories, restores the
// register defaults and empties the output.
`timescale 1ns / 1ps
`default_nettype none
module tof_channel_range_qualifier (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [2:0]                     i_channel,
    input  wire logic [15:0]                    i_distance_mm,
    input  wire logic [7:0]                     i_range_status,
    input  wire logic [15:0]                    i_ambient_raw,
    input  wire logic [15:0]                    i_spad_count,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [2:0]                          o_out_channel,
    output logic [15:0]                         o_filtered_distance,
    output logic [15:0]                         o_ambient_per_spad,
    output logic                                o_robot_now,
    output logic                                o_robot_recent,
    input  wire logic                           i_cfg_we,
    input  wire logic [1:0]                     i_cfg_index,
    input  wire logic [15:0]                    i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_MAC  = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [tcrq_pkg::DATA_W-1:0]       r_amb_thr;
    logic [tcrq_pkg::HLEN_W-1:0]       r_hist_len;
    logic [tcrq_pkg::WEIGHT_W-1:0]     r_weight;

    logic [tcrq_pkg::DATA_W-1:0]       r_last [tcrq_pkg::CHANNELS];
    logic [tcrq_pkg::MAX_HISTORY-1:0]  r_hist [tcrq_pkg::CHANNELS];

    logic [2:0]                        r_ch;
    logic                              r_in_range;
    logic [tcrq_pkg::DATA_W-1:0]       r_dist;
    logic                              r_status_bad;
    logic [tcrq_pkg::DATA_W-1:0]       r_stored;
    logic [tcrq_pkg::MAX_HISTORY-1:0]  r_hist_cur;
    logic [tcrq_pkg::DATA_W-1:0]       r_ratio;
    logic                              r_now;
    logic                              r_recent;
    logic [tcrq_pkg::DATA_W-1:0]       r_filt;

    logic                              r_out_valid;
    logic [2:0]                        r_out_ch;
    logic [tcrq_pkg::DATA_W-1:0]       r_out_dist;
    logic [tcrq_pkg::DATA_W-1:0]       r_out_ratio;
    logic                              r_out_now;
    logic                              r_out_recent;

    logic                              w_in_acc;
    logic                              w_out_free;
    logic                              w_in_range;
    logic [tcrq_pkg::CH_IDX_W-1:0]     w_in_idx;
    logic [tcrq_pkg::CH_IDX_W-1:0]     w_idx;
    tcrq_pkg::t_unit_ctl               w_div_ctl;
    tcrq_pkg::t_unit_ctl               w_mac_ctl;
    logic                              w_div_done;
    logic [tcrq_pkg::DATA_W-1:0]       w_quo;
    logic                              w_mac_done;
    logic [tcrq_pkg::DATA_W-1:0]       w_mac_res;
    logic                              w_now;
    logic [tcrq_pkg::MAX_HISTORY-1:0]  w_hist_new;
    logic [tcrq_pkg::DATA_W-1:0]       w_cur;
    logic [tcrq_pkg::WEIGHT_W-1:0]     w_weight;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_in_range = int'(i_channel) < tcrq_pkg::CHANNELS;
    assign w_in_idx   = i_channel[tcrq_pkg::CH_IDX_W-1:0];
    assign w_idx      = r_ch[tcrq_pkg::CH_IDX_W-1:0];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amb_thr  <= tcrq_pkg::RST_AMB_THR;
            r_hist_len <= tcrq_pkg::RST_HIST_LEN;
            r_weight   <= tcrq_pkg::RST_WEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tcrq_pkg::REG_AMB_THR:  r_amb_thr  <= i_cfg_data;
                tcrq_pkg::REG_HIST_LEN: r_hist_len <= i_cfg_data[tcrq_pkg::HLEN_W-1:0];
                tcrq_pkg::REG_WEIGHT:   r_weight   <= i_cfg_data[tcrq_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // per-word qualification, evaluated when the quotient lands
    always_comb begin
        w_now      = w_quo > r_amb_thr;
        w_hist_new = {r_hist_cur[tcrq_pkg::MAX_HISTORY-2:0], w_now};
        w_cur      = r_dist;
        if (r_dist < tcrq_pkg::MIN_VALID_MM) w_cur = tcrq_pkg::FAR_MM;
        if (r_status_bad) w_cur = w_now ? r_stored : tcrq_pkg::FAR_MM;
        w_weight   = (r_weight > tcrq_pkg::FULL_WEIGHT) ? tcrq_pkg::FULL_WEIGHT : r_weight;
    end

    assign w_div_ctl.start = w_in_acc;
    assign w_mac_ctl.start = (r_state == S_DIV) && w_div_done;

    tcrq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (i_ambient_raw),
        .i_divisor  (i_spad_count),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    tcrq_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_cur    (w_cur),
        .i_stored (r_stored),
        .i_weight (w_weight),
        .o_done   (w_mac_done),
        .o_result (w_mac_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_DIV;
            S_DIV:  if (w_div_done) n_state = S_MAC;
            S_MAC:  if (w_mac_done) n_state = S_WAIT;
            S_WAIT: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // word capture and intermediate results
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ch         <= i_channel;
            r_in_range   <= w_in_range;
            r_dist       <= i_distance_mm;
            r_status_bad <= (i_range_status != '0);
            r_stored     <= w_in_range ? r_last[w_in_idx] : '0;
            r_hist_cur   <= w_in_range ? r_hist[w_in_idx] : '0;
        end
        if (w_mac_ctl.start) begin
            r_ratio    <= w_quo;
            r_now      <= w_now;
            r_recent   <= |(w_hist_new & tcrq_pkg::hist_mask(r_hist_len));
            r_hist_cur <= w_hist_new;
        end
        if ((r_state == S_MAC) && w_mac_done) begin
            r_filt <= w_mac_res;
        end
    end

    // channel state, written back once the smoothed value is known
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tcrq_pkg::CHANNELS; i++) begin
                r_last[i] <= '0;
                r_hist[i] <= '0;
            end
        end else if ((r_state == S_MAC) && w_mac_done && r_in_range) begin
            r_last[w_idx] <= w_mac_res;
            r_hist[w_idx] <= r_hist_cur;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_WAIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if ((r_state == S_WAIT) && w_out_free) begin
            r_out_ch     <= r_ch;
            r_out_dist   <= r_filt;
            r_out_ratio  <= r_ratio;
            r_out_now    <= r_now;
            r_out_recent <= r_recent;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_channel       = r_out_ch;
    assign o_filtered_distance = r_out_dist;
    assign o_ambient_per_spad  = r_out_ratio;
    assign o_robot_now         = r_out_now;
    assign o_robot_recent      = r_out_recent;

`ifndef NO_ASSERTIONS
    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_DIV))
        else $error("accepted word did not start the divider");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_mac_done_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_done |-> (r_state == S_MAC))
        else $error("smoothing unit finished outside its phase");

    a_out_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_WAIT))
        else $error("output word appeared without a finished result");
`endif

endmodule
`default_nettype wire

// File: dv/tcrq_reading_checker.sv
`timescale 1ns / 1ps
module tcrq_reading_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [2:0]  i_channel,
    input  wire logic [15:0] i_distance_mm,
    input  wire logic [7:0]  i_range_status,
    input  wire logic [15:0] i_ambient_raw,
    input  wire logic [15:0] i_spad_count,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [2:0]  i_out_channel,
    input  wire logic [15:0] i_filtered_distance,
    input  wire logic [15:0] i_ambient_per_spad,
    input  wire logic        i_robot_now,
    input  wire logic        i_robot_recent,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    typedef struct packed {
        logic [2:0]  channel;
        logic [15:0] filtered;
        logic [15:0] ratio;
        logic        now;
        logic        recent;
    } t_qualified_word;

    logic [15:0]                      amb_thr;
    logic [tcrq_pkg::HLEN_W-1:0]      hist_len;
    logic [tcrq_pkg::WEIGHT_W-1:0]    weight;
    logic [15:0]                      last_mm   [tcrq_pkg::CHANNELS];
    logic [tcrq_pkg::MAX_HISTORY-1:0] flag_hist [tcrq_pkg::CHANNELS];

    t_qualified_word expected_words [$];

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        begin
            $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
            o_fail_count++;
        end
    endtask

    // computes one qualified word and advances the per-channel state
    function automatic t_qualified_word qualify_reading(
        input logic [2:0]  ch,
        input logic [15:0] dist_mm,
        input logic [7:0]  status,
        input logic [15:0] amb,
        input logic [15:0] spads
    );
        t_qualified_word                  res;
        logic                             in_range;
        logic [15:0]                      stored;
        logic [15:0]                      ratio;
        logic [15:0]                      cur;
        logic [tcrq_pkg::MAX_HISTORY-1:0] hist;
        logic                             now;
        logic                             recent;
        int                               len;
        int                               w;
        int unsigned                      acc;
        in_range = int'(ch) < tcrq_pkg::CHANNELS;
        stored   = in_range ? last_mm[ch] : 16'd0;
        hist     = in_range ? flag_hist[ch] : '0;

        ratio = (spads == 16'd0) ? 16'hFFFF : amb / spads;
        now   = ratio > amb_thr;

        len = int'(hist_len);
        if (len == 0) len = 1;
        if (len > tcrq_pkg::MAX_HISTORY) len = tcrq_pkg::MAX_HISTORY;
        hist   = {hist[tcrq_pkg::MAX_HISTORY-2:0], now};
        recent = 1'b0;
        for (int i = 0; i < len; i++) begin
            recent |= hist[i];
        end

        cur = (dist_mm < tcrq_pkg::MIN_VALID_MM) ? tcrq_pkg::FAR_MM : dist_mm;
        if (status != 8'd0) cur = now ? stored : tcrq_pkg::FAR_MM;

        w = int'(weight);
        if (w > int'(tcrq_pkg::FULL_WEIGHT)) w = int'(tcrq_pkg::FULL_WEIGHT);
        acc = int'(stored) * (int'(tcrq_pkg::FULL_WEIGHT) - w) + int'(cur) * w;

        res.channel  = ch;
        res.filtered = acc[23:8];
        res.ratio    = ratio;
        res.now      = now;
        res.recent   = recent;

        if (in_range) begin
            last_mm[ch]   = res.filtered;
            flag_hist[ch] = hist;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_qualified_word want;
        if (!i_rst_n) begin
            amb_thr  = tcrq_pkg::RST_AMB_THR;
            hist_len = tcrq_pkg::RST_HIST_LEN;
            weight   = tcrq_pkg::RST_WEIGHT;
            for (int c = 0; c < tcrq_pkg::CHANNELS; c++) begin
                last_mm[c]   = '0;
                flag_hist[c] = '0;
            end
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tcrq_pkg::REG_AMB_THR:  amb_thr  = i_cfg_data;
                    tcrq_pkg::REG_HIST_LEN: hist_len = i_cfg_data[tcrq_pkg::HLEN_W-1:0];
                    tcrq_pkg::REG_WEIGHT:   weight   = i_cfg_data[tcrq_pkg::WEIGHT_W-1:0];
                    default: ;
                endcase
            end
            // compare before pushing so a word can never match itself
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("output words pending", 0, 1);
                end else begin
                    want = expected_words.pop_front();
                    o_checked++;
                    if (i_out_channel !== want.channel)
                        report_mismatch("out_channel", want.channel, i_out_channel);
                    if (i_filtered_distance !== want.filtered)
                        report_mismatch("filtered_distance", want.filtered,
                                        i_filtered_distance);
                    if (i_ambient_per_spad !== want.ratio)
                        report_mismatch("ambient_per_spad", want.ratio, i_ambient_per_spad);
                    if (i_robot_now !== want.now)
                        report_mismatch("robot_now", want.now, i_robot_now);
                    if (i_robot_recent !== want.recent)
                        report_mismatch("robot_recent", want.recent, i_robot_recent);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_words.push_back(qualify_reading(i_channel, i_distance_mm,
                                                         i_range_status, i_ambient_raw,
                                                         i_spad_count));
            end
        end
        o_pending = expected_words.size();
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam logic [1:0] REG_SPARE   = 2'd3;
    localparam int         PHASES      = 9;
    localparam int         PHASE_WORDS = 130;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [2:0]  i_channel      = '0;
    logic [15:0] i_distance_mm  = '0;
    logic [7:0]  i_range_status = '0;
    logic [15:0] i_ambient_raw  = '0;
    logic [15:0] i_spad_count   = '0;
    logic        i_out_stall    = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [1:0]  i_cfg_index    = '0;
    logic [15:0] i_cfg_data     = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_out_channel;
    logic [15:0] o_filtered_distance;
    logic [15:0] o_ambient_per_spad;
    logic        o_robot_now;
    logic        o_robot_recent;

    int          fail_count;
    int          pending;
    int          checked;

    logic        no_idle   = 1'b0;
    logic [15:0] cur_thr   = tcrq_pkg::RST_AMB_THR;
    int          sent      = 0;
    int          settings  = 0;

    tof_channel_range_qualifier DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_channel           (i_channel),
        .i_distance_mm       (i_distance_mm),
        .i_range_status      (i_range_status),
        .i_ambient_raw       (i_ambient_raw),
        .i_spad_count        (i_spad_count),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_channel       (o_out_channel),
        .o_filtered_distance (o_filtered_distance),
        .o_ambient_per_spad  (o_ambient_per_spad),
        .o_robot_now         (o_robot_now),
        .o_robot_recent      (o_robot_recent),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    tcrq_reading_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_channel           (i_channel),
        .i_distance_mm       (i_distance_mm),
        .i_range_status      (i_range_status),
        .i_ambient_raw       (i_ambient_raw),
        .i_spad_count        (i_spad_count),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_out_channel       (o_out_channel),
        .i_filtered_distance (o_filtered_distance),
        .i_ambient_per_spad  (o_ambient_per_spad),
        .i_robot_now         (o_robot_now),
        .i_robot_recent      (o_robot_recent),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_checked           (checked)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(negedge i_clk) begin
        i_out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 22);
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // valid stays high after acceptance until the next negedge
    task automatic send_reading(input logic [2:0] ch, input logic [15:0] dist_mm,
                                input logic [7:0] status, input logic [15:0] amb,
                                input logic [15:0] spads);
        begin
            @(negedge i_clk);
            while (!no_idle && $urandom_range(99) < 22) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
            i_in_valid     <= 1'b1;
            i_channel      <= ch;
            i_distance_mm  <= dist_mm;
            i_range_status <= status;
            i_ambient_raw  <= amb;
            i_spad_count   <= spads;
            do @(posedge i_clk); while (o_in_stall);
            sent++;
        end
    endtask

    task automatic drain_words();
        begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            while (pending != 0) @(negedge i_clk);
            repeat (4) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            if (idx == tcrq_pkg::REG_AMB_THR) cur_thr = val;
            @(negedge i_clk);
            i_cfg_we    <= 1'b0;
        end
    endtask

    task automatic set_config(input logic [15:0] thr, input logic [15:0] len,
                              input logic [15:0] w);
        begin
            write_reg(tcrq_pkg::REG_AMB_THR, thr);
            write_reg(tcrq_pkg::REG_HIST_LEN, len);
            write_reg(tcrq_pkg::REG_WEIGHT, w);
            settings++;
        end
    endtask

    initial begin : stimulus
        logic [2:0]  ch;
        logic [15:0] dist_mm;
        logic [7:0]  status;
        logic [15:0] amb;
        logic [15:0] spads;
        longint      near_amb;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        settings = 1;

        // reset defaults: threshold 100, window of 4, no smoothing
        send_reading(3'd0, 16'd0,     8'd0,   16'd0,     16'd1);
        send_reading(3'd1, 16'd29,    8'd0,   16'd100,   16'd1);
        send_reading(3'd2, 16'd30,    8'd0,   16'd101,   16'd1);
        send_reading(3'd3, 16'hFFFF,  8'd0,   16'hFFFF,  16'd0);
        send_reading(3'd4, 16'd1234,  8'd0,   16'hFFFF,  16'hFFFF);
        send_reading(3'd5, 16'd500,   8'd0,   16'd0,     16'd0);
        // invalid status with robot keeps stored distance, without it goes far
        send_reading(3'd5, 16'd800,   8'hFF,  16'hFFFF,  16'd1);
        send_reading(3'd6, 16'd800,   8'd1,   16'd5,     16'd1);
        send_reading(3'd7, 16'hAAAA,  8'h55,  16'h5555,  16'h00AA);
        send_reading(3'd7, 16'h5555,  8'hAA,  16'hAAAA,  16'h0055);
        // robot flag on ch2 ages out of the window
        repeat (4) send_reading(3'd2, 16'd100, 8'd0, 16'd0, 16'd5);
        drain_words();

        set_config(16'd0, 16'd1, 16'd0);
        send_reading(3'd0, 16'd2000, 8'd0, 16'd0, 16'd9);
        send_reading(3'd0, 16'd3000, 8'd0, 16'd1, 16'd1);
        drain_words();

        // weight data masks to 511, clamped to full weight
        set_config(16'hFFFF, 16'd16, 16'hFFFF);
        send_reading(3'd1, 16'd700, 8'd0, 16'd0,     16'd0);
        send_reading(3'd1, 16'd900, 8'd0, 16'hFFFF,  16'd1);
        drain_words();

        set_config(16'd3, 16'h001F, 16'd1);
        write_reg(REG_SPARE, 16'hFFFF);
        send_reading(3'd4, 16'd60000, 8'd0, 16'd4, 16'd1);
        send_reading(3'd4, 16'd100,   8'd2, 16'd3, 16'd1);
        drain_words();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_config(16'd0, 16'd1, 16'd0);
                1: set_config(16'hFFFF, 16'd16, 16'd256);
                2: set_config(16'($urandom_range(0, 200)), 16'd0, 16'hFFFF);
                3: set_config(16'($urandom_range(0, 200)), 16'd17, 16'd255);
                default: set_config(16'($urandom_range(0, 300)),
                                    16'($urandom_range(0, 31)),
                                    16'($urandom_range(0, 511)));
            endcase
            no_idle = (p == 6);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                ch = 3'($urandom_range(0, 7));
                case ($urandom_range(0, 9))
                    0: dist_mm = 16'($urandom_range(0, 40));
                    1: dist_mm = 16'hFFFF;
                    default: dist_mm = 16'($urandom);
                endcase
                status = ($urandom_range(0, 9) < 7) ? 8'd0 : 8'($urandom_range(1, 255));
                case ($urandom_range(0, 19))
                    0: spads = 16'd0;
                    1, 2, 3, 4, 5, 6, 7, 8, 9: spads = 16'($urandom_range(1, 64));
                    default: spads = 16'($urandom);
                endcase
                // aim the ratio at the threshold so robot flags toggle often
                if ($urandom_range(0, 9) < 4 && spads != 16'd0) begin
                    near_amb = longint'(cur_thr) * spads + $urandom_range(0, 2 * spads)
                               - longint'(spads);
                    if (near_amb < 0) near_amb = 0;
                    if (near_amb > 65535) near_amb = 65535;
                    amb = 16'(near_amb);
                end else begin
                    amb = 16'($urandom);
                end
                send_reading(ch, dist_mm, status, amb, spads);
                if (p == 4 && n == PHASE_WORDS / 2) drain_words();
            end
            drain_words();
        end
        no_idle = 1'b0;

        repeat (40) @(negedge i_clk);
        $display("Sent %0d readings across %0d register settings, %0d words checked",
                 sent, settings, checked);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: tof_channel_range_qualifier.f
src/tcrq_pkg.sv
src/tcrq_div.sv
src/tcrq_mac.sv
src/tof_channel_range_qualifier.sv
dv/tcrq_reading_checker.sv
dv/tb.sv
